FILE: src/avg_pool_3x3_stride2_u8_unit_defines.svh
// ----------------------------------------------------------------------------
// avg_pool_3x3_stride2_u8_unit defines
// assertion macros shared by the pooling unit
// ----------------------------------------------------------------------------
`ifndef AVG_POOL_3X3_STRIDE2_U8_UNIT_DEFINES_SVH
`define AVG_POOL_3X3_STRIDE2_U8_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define AP3S2_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define AP3S2_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ap3s2_pkg.sv
// ----------------------------------------------------------------------------
// ap3s2_pkg
// widths, register codes and the divide-by-nine helper of the pooling unit
// ----------------------------------------------------------------------------
`default_nettype none

package ap3s2_pkg;

    localparam int PIX_W      = 8;
    localparam int HSUM_W     = 10;
    localparam int PART_W     = 12;
    localparam int TOT_W      = 13;
    localparam int COORD_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd129;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd97;

    // reciprocal of 9 scaled by 2^17, rounded up; exact for totals below 2^13
    localparam int DIV9_SHIFT = 17;
    localparam int DIV9_MUL_W = 15;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MULT = 15'd14564;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1
    } cfg_reg_t;

    function automatic logic [PIX_W-1:0] div9(input logic [TOT_W-1:0] total);
        logic [TOT_W+DIV9_MUL_W-1:0] prod;
        prod = (TOT_W+DIV9_MUL_W)'(total) * (TOT_W+DIV9_MUL_W)'(DIV9_MULT);
        return PIX_W'(prod >> DIV9_SHIFT);
    endfunction

endpackage

`default_nettype wire

FILE: src/ap3s2_ifs.sv
// ----------------------------------------------------------------------------
// ap3s2 channel interfaces
// pixel input, pooled output and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface ap3s2_pix_if;
    logic                          valid;
    logic                          ready;
    logic [ap3s2_pkg::PIX_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface ap3s2_pool_if;
    logic                          valid;
    logic                          ready;
    logic [ap3s2_pkg::PIX_W-1:0]   average;
    logic [ap3s2_pkg::COORD_W-1:0] out_x;
    logic [ap3s2_pkg::COORD_W-1:0] out_y;
    logic                          end_of_frame;

    modport source (output valid, output average, output out_x, output out_y,
                    output end_of_frame, input ready);
    modport sink   (input valid, input average, input out_x, input out_y,
                    input end_of_frame, output ready);
endinterface

interface ap3s2_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ap3s2_pkg::CFG_IDX_W-1:0]  index;
    logic [ap3s2_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ap3s2_line_store.sv
// ----------------------------------------------------------------------------
// ap3s2_line_store
// one-write one-read line memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ap3s2_line_store #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 12
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/avg_pool_3x3_stride2_u8_unit.sv
// timing: the input word that completes a window is held in the stage-1
//   registers, and its pooled word is then loaded into the output register
// throughput: 1 pixel per cycle while the output is not stalled, set by the
//   line-store read in the accept cycle and the sum and divide in the cycle after it
// reset clears counters, pixel history, handshake state and the size
//   registers (129 x 97); line stores hold no reset contents
// ----------------------------------------------------------------------------
// avg_pool_3x3_stride2_u8_unit
// 3x3 average pooling at stride 2 with edge clamping over a raster stream
// ----------------------------------------------------------------------------
`default_nettype none

module avg_pool_3x3_stride2_u8_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ap3s2_pix_if.sink        pix_in,
    ap3s2_pool_if.source     pool_out,
    ap3s2_cfg_if.sink        cfg
);

`include "avg_pool_3x3_stride2_u8_unit_defines.svh"

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WH    = $clog2(MAX_HEIGHT + 1);
    localparam int SW0   = (WW > WH) ? WW : WH;
    localparam int SW    = (SW0 > ap3s2_pkg::CFG_DATA_W) ? SW0 : ap3s2_pkg::CFG_DATA_W;
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = $clog2(DEPTH);

    localparam int PW = ap3s2_pkg::PIX_W;
    localparam int HW = ap3s2_pkg::HSUM_W;
    localparam int QW = ap3s2_pkg::PART_W;
    localparam int TW = ap3s2_pkg::TOT_W;
    localparam int OW = ap3s2_pkg::COORD_W;

    // configuration
    logic [ap3s2_pkg::CFG_DATA_W-1:0] width_reg;
    logic [ap3s2_pkg::CFG_DATA_W-1:0] height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ap3s2_pkg::WIDTH_RESET;
            height_reg <= ap3s2_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ap3s2_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                ap3s2_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // effective sizes clamped to [2, max]
    logic [SW-1:0] w_ext;
    logic [SW-1:0] h_ext;
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;

    always_comb
    begin
        w_ext = SW'(width_reg);
        h_ext = SW'(height_reg);
        if (w_ext < SW'(2))
            w_eff = SW'(2);
        else if (w_ext > SW'(MAX_WIDTH))
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext < SW'(2))
            h_eff = SW'(2);
        else if (h_ext > SW'(MAX_HEIGHT))
            h_eff = SW'(MAX_HEIGHT);
        else
            h_eff = h_ext;
    end

    // raster position and pixel history
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] prev2_reg;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          x_odd;
    logic          uses_store;
    logic [PW-1:0] left_pix;
    logic [HW-1:0] hsum;
    logic [AW-1:0] ox;
    logic [CW-1:0] col_half;
    logic [RW-1:0] row_half;

    assign accept     = pix_in.valid && pix_in.ready;
    assign last_col   = (SW'(col_reg) + SW'(1)) >= w_eff;
    assign last_row   = (SW'(row_reg) + SW'(1)) >= h_eff;
    assign x_odd      = col_reg[0];
    assign uses_store = x_odd || last_col;
    assign col_half   = col_reg >> 1;
    assign row_half   = row_reg >> 1;
    assign ox         = AW'(col_half);
    // left neighbor clamps to the center at column one
    assign left_pix   = (col_reg == CW'(1)) ? prev_reg : prev2_reg;

    always_comb
    begin
        if (x_odd)
            hsum = HW'(left_pix) + HW'(prev_reg) + HW'(pix_in.pixel);
        else
            hsum = HW'(prev_reg) + (HW'(pix_in.pixel) << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else if (accept)
        begin
            prev2_reg <= prev_reg;
            prev_reg  <= pix_in.pixel;
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // stage 1: window column sum, waiting on the line-store read
    logic          s1_valid_reg;
    logic [HW-1:0] s1_hsum_reg;
    logic [AW-1:0] s1_ox_reg;
    logic          s1_row0_reg;
    logic          s1_row_odd_reg;
    logic          s1_emit_reg;
    logic          s1_eof_reg;
    logic [OW-1:0] s1_x_reg;
    logic [OW-1:0] s1_y_reg;
    logic          s1_adv;

    logic          out_valid_reg;
    logic [PW-1:0] out_avg_reg;
    logic [OW-1:0] out_x_reg;
    logic [OW-1:0] out_y_reg;
    logic          out_eof_reg;

    assign s1_adv       = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || pool_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            s1_valid_reg <= accept && uses_store;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && uses_store)
        begin
            s1_hsum_reg    <= hsum;
            s1_ox_reg      <= ox;
            s1_row0_reg    <= (row_reg == '0);
            s1_row_odd_reg <= row_reg[0];
            s1_emit_reg    <= row_reg[0] || last_row;
            s1_eof_reg     <= last_col && last_row;
            s1_x_reg       <= OW'(col_half);
            s1_y_reg       <= OW'(row_half);
        end
    end

    // line stores: odd-row column sums and even-row partial totals
    logic [HW-1:0] odd_rd;
    logic [QW-1:0] part_rd;
    logic [QW-1:0] part_new;
    logic [TW-1:0] total;

    ap3s2_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (HW)
    ) u_odd_store (
        .clk     (clk),
        .wr_en   (s1_adv && s1_row_odd_reg),
        .wr_addr (s1_ox_reg),
        .wr_data (s1_hsum_reg),
        .rd_en   (accept && uses_store),
        .rd_addr (ox),
        .rd_data (odd_rd)
    );

    ap3s2_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (QW)
    ) u_part_store (
        .clk     (clk),
        .wr_en   (s1_adv && !s1_row_odd_reg),
        .wr_addr (s1_ox_reg),
        .wr_data (part_new),
        .rd_en   (accept && uses_store),
        .rd_addr (ox),
        .rd_data (part_rd)
    );

    always_comb
    begin
        // top row clamps to the center row at row zero
        if (s1_row0_reg)
            part_new = QW'(s1_hsum_reg) << 1;
        else
            part_new = QW'(odd_rd) + QW'(s1_hsum_reg);
        if (s1_row_odd_reg)
            total = TW'(part_rd) + TW'(s1_hsum_reg);
        else
            total = TW'(part_new) + TW'(s1_hsum_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pool_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_avg_reg <= ap3s2_pkg::div9(total);
            out_x_reg   <= s1_x_reg;
            out_y_reg   <= s1_y_reg;
            out_eof_reg <= s1_eof_reg;
        end
    end

    assign pool_out.valid        = out_valid_reg;
    assign pool_out.average      = out_avg_reg;
    assign pool_out.out_x        = out_x_reg;
    assign pool_out.out_y        = out_y_reg;
    assign pool_out.end_of_frame = out_eof_reg;

    `AP3S2_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        s1_valid_reg && !s1_adv, !pix_in.ready, "input taken while stage 1 stalled")

    `AP3S2_ASSERT_NEXT(a_stall_holds_stage1, clk, rst_n,
        s1_valid_reg && !s1_adv, s1_valid_reg, "stage 1 word lost during stall")

    `AP3S2_ASSERT_NEXT(a_frame_wraps, clk, rst_n,
        accept && last_col && last_row, col_reg == '0 && row_reg == '0,
        "raster position did not wrap at end of frame")

endmodule

`default_nettype wire
